/* rtl/tsfc_pkg.sv */
// shared types, constants and width helpers for the touch sample filter and calibrator
package tsfc_pkg;

    // default burst length per axis
    localparam int DEF_SAMPLES_PER_AXIS = 8;

    // fixed field widths
    localparam int SMP_W     = 8;
    localparam int SMP_MAX   = 255;
    localparam int MEAN_W    = 8;
    localparam int PT_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int OFF_W     = 11;
    localparam int SIZE_W    = 10;
    localparam int LIMIT_W   = 20;
    localparam int MODE_W    = 2;
    localparam int FRAC_W    = 14;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // gain times raw mean, and the display sum in units of 2^-14
    localparam int P_W = GAIN_W + MEAN_W + 1;
    localparam int T_W = P_W + 2;

    // request codes
    localparam logic [1:0] REQ_X   = 2'd0;
    localparam logic [1:0] REQ_Y   = 2'd1;
    localparam logic [1:0] REQ_REL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT  = 3'd7;

    // register reset values (offsets are -22 and -38 in 11-bit two's complement)
    localparam logic [MODE_W-1:0]  SCAN_MODE_RST     = 2'd0;
    localparam logic [GAIN_W-1:0]  X_GAIN_RST        = 16'd1473;
    localparam logic [GAIN_W-1:0]  Y_GAIN_RST        = 16'd2182;
    localparam logic [OFF_W-1:0]   X_OFFSET_RST      = 11'h7EA;
    localparam logic [OFF_W-1:0]   Y_OFFSET_RST      = 11'h7DA;
    localparam logic [SIZE_W-1:0]  SCREEN_WIDTH_RST  = 10'd480;
    localparam logic [SIZE_W-1:0]  SCREEN_HEIGHT_RST = 10'd320;
    localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RST  = 20'd128;

    // raw point after a release with the pen up
    localparam logic [PT_W-1:0] RAW_IDLE = 16'hffff;

    // configuration register set
    typedef struct packed {
        logic [MODE_W-1:0]  scan_mode;
        logic [GAIN_W-1:0]  x_gain;
        logic [GAIN_W-1:0]  y_gain;
        logic [OFF_W-1:0]   x_offset;
        logic [OFF_W-1:0]   y_offset;
        logic [SIZE_W-1:0]  screen_width;
        logic [SIZE_W-1:0]  screen_height;
        logic [LIMIT_W-1:0] spread_limit;
    } tsfc_cfg_t;

    // pipeline control: a word in flight, release or burst evaluation
    typedef struct packed {
        logic valid;
        logic rel;
    } tsfc_ctl_t;

    // accumulator and burst counter widths for a burst of n samples
    function automatic int sum_w(input int n);
        return $clog2(SMP_MAX * n + 1);
    endfunction

    function automatic int sq_w(input int n);
        return $clog2(SMP_MAX * SMP_MAX * n + 1);
    endfunction

    function automatic int cnt_w(input int n);
        return $clog2(2 * n + 1);
    endfunction

endpackage

/* rtl/tsfc_accum.sv */
// input register, burst phase tracking and per-axis sum / sum of squares
module tsfc_accum import tsfc_pkg::*; #(
    parameter int SAMPLES_PER_AXIS = DEF_SAMPLES_PER_AXIS,
    parameter int SUM_W = sum_w(SAMPLES_PER_AXIS),
    parameter int SQ_W  = sq_w(SAMPLES_PER_AXIS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       req_type,
    input  logic [SMP_W-1:0] sample,
    output tsfc_ctl_t        ev,
    output logic [SUM_W-1:0] ev_x_sum,
    output logic [SQ_W-1:0]  ev_x_sq,
    output logic [SUM_W-1:0] ev_y_sum,
    output logic [SQ_W-1:0]  ev_y_sq
);

    localparam int CNT_W = cnt_w(SAMPLES_PER_AXIS);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(SAMPLES_PER_AXIS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * SAMPLES_PER_AXIS - 1);

    logic             in_valid_reg;
    logic [1:0]       in_req_reg;
    logic [SMP_W-1:0] in_smp_reg;

    logic [SUM_W-1:0] x_sum_reg, x_sum_next, y_sum_reg, y_sum_next;
    logic [SQ_W-1:0]  x_sq_reg, x_sq_next, y_sq_reg, y_sq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    tsfc_ctl_t        ev_reg, ev_next;
    logic [SUM_W-1:0] ex_sum_reg, ex_sum_next, ey_sum_reg, ey_sum_next;
    logic [SQ_W-1:0]  ex_sq_reg, ex_sq_next, ey_sq_reg, ey_sq_next;

    logic [2*SMP_W-1:0] smp_sq;
    logic [SUM_W-1:0]   y_sum_add;
    logic [SQ_W-1:0]    y_sq_add;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg <= req_type;
        in_smp_reg <= sample;
    end

    // square of the current sample and y totals including it
    assign smp_sq    = (2*SMP_W)'(in_smp_reg) * (2*SMP_W)'(in_smp_reg);
    assign y_sum_add = y_sum_reg + SUM_W'(in_smp_reg);
    assign y_sq_add  = y_sq_reg + SQ_W'(smp_sq);

    // burst phase and accumulation
    always_comb
    begin
        x_sum_next  = x_sum_reg;
        x_sq_next   = x_sq_reg;
        y_sum_next  = y_sum_reg;
        y_sq_next   = y_sq_reg;
        cnt_next    = cnt_reg;
        ev_next     = '0;
        ex_sum_next = ex_sum_reg;
        ex_sq_next  = ex_sq_reg;
        ey_sum_next = ey_sum_reg;
        ey_sq_next  = ey_sq_reg;
        if (in_valid_reg)
        begin
            case (in_req_reg)
                REQ_REL:
                begin
                    x_sum_next  = '0;
                    x_sq_next   = '0;
                    y_sum_next  = '0;
                    y_sq_next   = '0;
                    cnt_next    = '0;
                    ev_next.valid = 1'b1;
                    ev_next.rel   = 1'b1;
                end
                REQ_X:
                begin
                    if (cnt_reg < N_CNT)
                    begin
                        x_sum_next = x_sum_reg + SUM_W'(in_smp_reg);
                        x_sq_next  = x_sq_reg + SQ_W'(smp_sq);
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
                REQ_Y:
                begin
                    if (cnt_reg >= N_CNT)
                    begin
                        if (cnt_reg == LAST_CNT)
                        begin
                            // last y word: hand the burst on and clear
                            ev_next.valid = 1'b1;
                            ex_sum_next   = x_sum_reg;
                            ex_sq_next    = x_sq_reg;
                            ey_sum_next   = y_sum_add;
                            ey_sq_next    = y_sq_add;
                            x_sum_next    = '0;
                            x_sq_next     = '0;
                            y_sum_next    = '0;
                            y_sq_next     = '0;
                            cnt_next      = '0;
                        end
                        else
                        begin
                            y_sum_next = y_sum_add;
                            y_sq_next  = y_sq_add;
                            cnt_next   = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // accumulators and event control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_sum_reg <= '0;
            x_sq_reg  <= '0;
            y_sum_reg <= '0;
            y_sq_reg  <= '0;
            cnt_reg   <= '0;
            ev_reg    <= '0;
        end
        else
        begin
            x_sum_reg <= x_sum_next;
            x_sq_reg  <= x_sq_next;
            y_sum_reg <= y_sum_next;
            y_sq_reg  <= y_sq_next;
            cnt_reg   <= cnt_next;
            ev_reg    <= ev_next;
        end
    end

    // finished burst totals
    always_ff @(posedge clk)
    begin
        ex_sum_reg <= ex_sum_next;
        ex_sq_reg  <= ex_sq_next;
        ey_sum_reg <= ey_sum_next;
        ey_sq_reg  <= ey_sq_next;
    end

    assign ev       = ev_reg;
    assign ev_x_sum = ex_sum_reg;
    assign ev_x_sq  = ex_sq_reg;
    assign ev_y_sum = ey_sum_reg;
    assign ev_y_sq  = ey_sq_reg;

endmodule

/* rtl/tsfc_eval.sv */
// means by reciprocal multiply, then spread products and calibration products
module tsfc_eval import tsfc_pkg::*; #(
    parameter int SAMPLES_PER_AXIS = DEF_SAMPLES_PER_AXIS,
    parameter int SUM_W = sum_w(SAMPLES_PER_AXIS),
    parameter int SQ_W  = sq_w(SAMPLES_PER_AXIS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsfc_cfg_t              cfg,
    input  tsfc_ctl_t              ev,
    input  logic [SUM_W-1:0]       ev_x_sum,
    input  logic [SQ_W-1:0]        ev_x_sq,
    input  logic [SUM_W-1:0]       ev_y_sum,
    input  logic [SQ_W-1:0]        ev_y_sq,
    output tsfc_ctl_t              pr,
    output logic [MEAN_W-1:0]      pr_xm,
    output logic [MEAN_W-1:0]      pr_ym,
    output logic [MEAN_W+SUM_W-1:0] pr_x_ms,
    output logic [2*MEAN_W-1:0]    pr_x_mm,
    output logic [MEAN_W+SUM_W-1:0] pr_y_ms,
    output logic [2*MEAN_W-1:0]    pr_y_mm,
    output logic [SQ_W-1:0]        pr_x_sq,
    output logic [SQ_W-1:0]        pr_y_sq,
    output logic signed [P_W-1:0]  pr_px,
    output logic signed [P_W-1:0]  pr_py
);

    // floor(sum / N) == (sum * ceil(2^SH / N)) >> SH for every sum below 2^SUM_W
    localparam int SH   = SUM_W + 4;
    localparam int RC_W = SH + 1;
    localparam int PR_W = SUM_W + RC_W;
    localparam logic [RC_W-1:0] RECIP =
        RC_W'(((64'd1 << SH) + 64'(SAMPLES_PER_AXIS) - 64'd1) / 64'(SAMPLES_PER_AXIS));
    localparam int MS_W = MEAN_W + SUM_W;

    logic [PR_W-1:0] x_prod, y_prod;

    tsfc_ctl_t         s2_ctl_reg;
    logic [MEAN_W-1:0] s2_xm_reg, s2_ym_reg;
    logic [SUM_W-1:0]  s2_x_sum_reg, s2_y_sum_reg;
    logic [SQ_W-1:0]   s2_x_sq_reg, s2_y_sq_reg;

    logic [MEAN_W-1:0] hx, hy;

    tsfc_ctl_t              s3_ctl_reg;
    logic [MEAN_W-1:0]      s3_xm_reg, s3_ym_reg;
    logic [MS_W-1:0]        s3_x_ms_reg, s3_y_ms_reg;
    logic [2*MEAN_W-1:0]    s3_x_mm_reg, s3_y_mm_reg;
    logic [SQ_W-1:0]        s3_x_sq_reg, s3_y_sq_reg;
    logic signed [P_W-1:0]  s3_px_reg, s3_py_reg;

    // mean of each axis
    assign x_prod = PR_W'(ev_x_sum) * PR_W'(RECIP);
    assign y_prod = PR_W'(ev_y_sum) * PR_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg <= ev;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_xm_reg    <= MEAN_W'(x_prod >> SH);
        s2_ym_reg    <= MEAN_W'(y_prod >> SH);
        s2_x_sum_reg <= ev_x_sum;
        s2_y_sum_reg <= ev_y_sum;
        s2_x_sq_reg  <= ev_x_sq;
        s2_y_sq_reg  <= ev_y_sq;
    end

    // axis routing for the display mapping
    assign hx = cfg.scan_mode[1] ? s2_ym_reg : s2_xm_reg;
    assign hy = cfg.scan_mode[1] ? s2_xm_reg : s2_ym_reg;

    // spread and gain products
    always_ff @(posedge clk)
    begin
        s3_xm_reg   <= s2_xm_reg;
        s3_ym_reg   <= s2_ym_reg;
        s3_x_ms_reg <= MS_W'(s2_xm_reg) * MS_W'(s2_x_sum_reg);
        s3_y_ms_reg <= MS_W'(s2_ym_reg) * MS_W'(s2_y_sum_reg);
        s3_x_mm_reg <= (2*MEAN_W)'(s2_xm_reg) * (2*MEAN_W)'(s2_xm_reg);
        s3_y_mm_reg <= (2*MEAN_W)'(s2_ym_reg) * (2*MEAN_W)'(s2_ym_reg);
        s3_x_sq_reg <= s2_x_sq_reg;
        s3_y_sq_reg <= s2_y_sq_reg;
        s3_px_reg   <= P_W'($signed(cfg.x_gain)) * P_W'($signed({1'b0, hx}));
        s3_py_reg   <= P_W'($signed(cfg.y_gain)) * P_W'($signed({1'b0, hy}));
    end

    assign pr      = s3_ctl_reg;
    assign pr_xm   = s3_xm_reg;
    assign pr_ym   = s3_ym_reg;
    assign pr_x_ms = s3_x_ms_reg;
    assign pr_x_mm = s3_x_mm_reg;
    assign pr_y_ms = s3_y_ms_reg;
    assign pr_y_mm = s3_y_mm_reg;
    assign pr_x_sq = s3_x_sq_reg;
    assign pr_y_sq = s3_y_sq_reg;
    assign pr_px   = s3_px_reg;
    assign pr_py   = s3_py_reg;

endmodule

/* rtl/tsfc_track.sv */
// spread check, display mapping, press status and result registers
module tsfc_track import tsfc_pkg::*; #(
    parameter int SAMPLES_PER_AXIS = DEF_SAMPLES_PER_AXIS,
    parameter int SUM_W = sum_w(SAMPLES_PER_AXIS),
    parameter int SQ_W  = sq_w(SAMPLES_PER_AXIS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tsfc_cfg_t               cfg,
    input  tsfc_ctl_t               pr,
    input  logic [MEAN_W-1:0]       pr_xm,
    input  logic [MEAN_W-1:0]       pr_ym,
    input  logic [MEAN_W+SUM_W-1:0] pr_x_ms,
    input  logic [2*MEAN_W-1:0]     pr_x_mm,
    input  logic [MEAN_W+SUM_W-1:0] pr_y_ms,
    input  logic [2*MEAN_W-1:0]     pr_y_mm,
    input  logic [SQ_W-1:0]         pr_x_sq,
    input  logic [SQ_W-1:0]         pr_y_sq,
    input  logic signed [P_W-1:0]   pr_px,
    input  logic signed [P_W-1:0]   pr_py,
    output logic                    done,
    output logic                    pen_down,
    output logic                    was_pressed,
    output logic                    sample_ok,
    output logic [PT_W-1:0]         raw_x,
    output logic [PT_W-1:0]         raw_y,
    output logic [PT_W-1:0]         draw_x,
    output logic [PT_W-1:0]         draw_y,
    output logic [PT_W-1:0]         first_x,
    output logic [PT_W-1:0]         first_y
);

    localparam int SPR_W = ((SQ_W > LIMIT_W) ? SQ_W : LIMIT_W) + 3;

    logic [SPR_W-1:0] spr_x, spr_y;
    logic             x_ok, y_ok, pt_ok;
    logic [PT_W-1:0]  dx, dy;

    logic            done_reg, done_next;
    logic            down_reg, down_next;
    logic            pressed_reg, pressed_next;
    logic            ok_reg, ok_next;
    logic [PT_W-1:0] raw_x_reg, raw_x_next, raw_y_reg, raw_y_next;
    logic [PT_W-1:0] draw_x_reg, draw_x_next, draw_y_reg, draw_y_next;
    logic [PT_W-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;

    // gain * raw + offset, or size - that in a mirrored mode; floor at zero
    function automatic logic [PT_W-1:0] to_disp(
        input logic signed [P_W-1:0] p,
        input logic [OFF_W-1:0]      off,
        input logic                  mir,
        input logic [SIZE_W-1:0]     size
    );
        logic signed [T_W-1:0] o;
        logic signed [T_W-1:0] s;
        logic signed [T_W-1:0] t;
        o = T_W'($signed({off, {FRAC_W{1'b0}}}));
        s = T_W'({size, {FRAC_W{1'b0}}});
        t = mir ? (s - T_W'(p) - o) : (T_W'(p) + o);
        if (t[T_W-1])
        begin
            return '0;
        end
        return PT_W'(t[T_W-1:FRAC_W]);
    endfunction

    // spread per axis: sumsq - 2*mean*sum + N*mean^2
    assign spr_x = SPR_W'(pr_x_sq) - SPR_W'({pr_x_ms, 1'b0})
                 + SPR_W'(pr_x_mm) * SPR_W'(SAMPLES_PER_AXIS);
    assign spr_y = SPR_W'(pr_y_sq) - SPR_W'({pr_y_ms, 1'b0})
                 + SPR_W'(pr_y_mm) * SPR_W'(SAMPLES_PER_AXIS);
    assign x_ok  = $signed(spr_x) < $signed(SPR_W'(cfg.spread_limit));
    assign y_ok  = $signed(spr_y) < $signed(SPR_W'(cfg.spread_limit));
    assign pt_ok = x_ok && y_ok;

    // display point
    assign dx = to_disp(pr_px, cfg.x_offset, cfg.scan_mode[0], cfg.screen_width);
    assign dy = to_disp(pr_py, cfg.y_offset, cfg.scan_mode[0], cfg.screen_height);

    // press status and stored points
    always_comb
    begin
        done_next    = pr.valid;
        down_next    = down_reg;
        pressed_next = pressed_reg;
        ok_next      = ok_reg;
        raw_x_next   = raw_x_reg;
        raw_y_next   = raw_y_reg;
        draw_x_next  = draw_x_reg;
        draw_y_next  = draw_y_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        if (pr.valid)
        begin
            if (pr.rel)
            begin
                ok_next = 1'b0;
                if (down_reg)
                begin
                    down_next = 1'b0;
                end
                else
                begin
                    first_x_next = '0;
                    first_y_next = '0;
                    raw_x_next   = RAW_IDLE;
                    raw_y_next   = RAW_IDLE;
                end
            end
            else
            begin
                ok_next = pt_ok;
                if (pt_ok)
                begin
                    raw_x_next  = PT_W'(pr_xm);
                    raw_y_next  = PT_W'(pr_ym);
                    draw_x_next = dx;
                    draw_y_next = dy;
                end
                if (!down_reg)
                begin
                    down_next    = 1'b1;
                    pressed_next = 1'b1;
                    first_x_next = raw_x_next;
                    first_y_next = raw_y_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            down_reg    <= 1'b0;
            pressed_reg <= 1'b0;
            ok_reg      <= 1'b0;
            raw_x_reg   <= '0;
            raw_y_reg   <= '0;
            draw_x_reg  <= '0;
            draw_y_reg  <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
        end
        else
        begin
            done_reg    <= done_next;
            down_reg    <= down_next;
            pressed_reg <= pressed_next;
            ok_reg      <= ok_next;
            raw_x_reg   <= raw_x_next;
            raw_y_reg   <= raw_y_next;
            draw_x_reg  <= draw_x_next;
            draw_y_reg  <= draw_y_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
        end
    end

    assign done        = done_reg;
    assign pen_down    = down_reg;
    assign was_pressed = pressed_reg;
    assign sample_ok   = ok_reg;
    assign raw_x       = raw_x_reg;
    assign raw_y       = raw_y_reg;
    assign draw_x      = draw_x_reg;
    assign draw_y      = draw_y_reg;
    assign first_x     = first_x_reg;
    assign first_y     = first_y_reg;

endmodule

/* rtl/touch_sample_filter_calibrate_unit.sv */
// Touch sample filter and calibrator, top level.
// Pipeline: a word accepted at a clock edge passes the input register plus four stages
// and then shows its result, if any, with done high.
// Throughput: one word per cycle; busy stays low, the stages are a plain pipeline.
// Reset: rst_n clears accumulators, press status, stored points and loads register defaults.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module touch_sample_filter_calibrate_unit import tsfc_pkg::*; #(
    parameter int SAMPLES_PER_AXIS = DEF_SAMPLES_PER_AXIS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [SMP_W-1:0]     sample,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic                 pen_down,
    output logic                 was_pressed,
    output logic                 sample_ok,
    output logic [PT_W-1:0]      raw_x,
    output logic [PT_W-1:0]      raw_y,
    output logic [PT_W-1:0]      draw_x,
    output logic [PT_W-1:0]      draw_y,
    output logic [PT_W-1:0]      first_x,
    output logic [PT_W-1:0]      first_y
);

    localparam int SUM_W = sum_w(SAMPLES_PER_AXIS);
    localparam int SQ_W  = sq_w(SAMPLES_PER_AXIS);

    tsfc_cfg_t cfg_reg;

    tsfc_ctl_t        ev;
    logic [SUM_W-1:0] ev_x_sum, ev_y_sum;
    logic [SQ_W-1:0]  ev_x_sq, ev_y_sq;

    tsfc_ctl_t                pr;
    logic [MEAN_W-1:0]        pr_xm, pr_ym;
    logic [MEAN_W+SUM_W-1:0]  pr_x_ms, pr_y_ms;
    logic [2*MEAN_W-1:0]      pr_x_mm, pr_y_mm;
    logic [SQ_W-1:0]          pr_x_sq, pr_y_sq;
    logic signed [P_W-1:0]    pr_px, pr_py;

    // every stage takes a new word each cycle
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_mode     <= SCAN_MODE_RST;
            cfg_reg.x_gain        <= X_GAIN_RST;
            cfg_reg.y_gain        <= Y_GAIN_RST;
            cfg_reg.x_offset      <= X_OFFSET_RST;
            cfg_reg.y_offset      <= Y_OFFSET_RST;
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.spread_limit  <= SPREAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_MODE:     cfg_reg.scan_mode     <= cfg_data[MODE_W-1:0];
                CFG_X_GAIN:        cfg_reg.x_gain        <= cfg_data[GAIN_W-1:0];
                CFG_Y_GAIN:        cfg_reg.y_gain        <= cfg_data[GAIN_W-1:0];
                CFG_X_OFFSET:      cfg_reg.x_offset      <= cfg_data[OFF_W-1:0];
                CFG_Y_OFFSET:      cfg_reg.y_offset      <= cfg_data[OFF_W-1:0];
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SIZE_W-1:0];
                CFG_SPREAD_LIMIT:  cfg_reg.spread_limit  <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // burst accumulation
    tsfc_accum #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
        .SUM_W            (SUM_W),
        .SQ_W             (SQ_W)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .req_type (req_type),
        .sample   (sample),
        .ev       (ev),
        .ev_x_sum (ev_x_sum),
        .ev_x_sq  (ev_x_sq),
        .ev_y_sum (ev_y_sum),
        .ev_y_sq  (ev_y_sq)
    );

    // means and products
    tsfc_eval #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
        .SUM_W            (SUM_W),
        .SQ_W             (SQ_W)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ev       (ev),
        .ev_x_sum (ev_x_sum),
        .ev_x_sq  (ev_x_sq),
        .ev_y_sum (ev_y_sum),
        .ev_y_sq  (ev_y_sq),
        .pr       (pr),
        .pr_xm    (pr_xm),
        .pr_ym    (pr_ym),
        .pr_x_ms  (pr_x_ms),
        .pr_x_mm  (pr_x_mm),
        .pr_y_ms  (pr_y_ms),
        .pr_y_mm  (pr_y_mm),
        .pr_x_sq  (pr_x_sq),
        .pr_y_sq  (pr_y_sq),
        .pr_px    (pr_px),
        .pr_py    (pr_py)
    );

    // spread check, calibration and press tracking
    tsfc_track #(
        .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS),
        .SUM_W            (SUM_W),
        .SQ_W             (SQ_W)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pr          (pr),
        .pr_xm       (pr_xm),
        .pr_ym       (pr_ym),
        .pr_x_ms     (pr_x_ms),
        .pr_x_mm     (pr_x_mm),
        .pr_y_ms     (pr_y_ms),
        .pr_y_mm     (pr_y_mm),
        .pr_x_sq     (pr_x_sq),
        .pr_y_sq     (pr_y_sq),
        .pr_px       (pr_px),
        .pr_py       (pr_py),
        .done        (done),
        .pen_down    (pen_down),
        .was_pressed (was_pressed),
        .sample_ok   (sample_ok),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .draw_x      (draw_x),
        .draw_y      (draw_y),
        .first_x     (first_x),
        .first_y     (first_y)
    );

endmodule

/* rtl/tsfc_checker.sv */
// port-level checks for the touch sample filter and calibrator, bound to the top level
module tsfc_checker import tsfc_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [1:0]      req_type,
    input logic            done,
    input logic            pen_down,
    input logic            was_pressed,
    input logic            sample_ok,
    input logic [PT_W-1:0] raw_x
);

    // every accepted release word gives a result back with done high
    a_rel_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_REL) |-> ##5 done)
        else $error("release word gave no result");

    // an unused request code gives nothing back
    a_unused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type != REQ_X && req_type != REQ_Y && req_type != REQ_REL)
        |-> ##5 !done)
        else $error("unused request code gave a result");

    // pen down implies the sticky pressed bit
    a_down_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pen_down) |-> was_pressed)
        else $error("pen down without pressed");

    // an accepted point always leaves the pen down
    a_ok_down: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sample_ok) |-> (pen_down && was_pressed))
        else $error("accepted point without pen down");

    // before any press a result can only be an idle release
    a_idle_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_pressed) |-> (raw_x == RAW_IDLE && !sample_ok))
        else $error("idle result without idle raw point");

endmodule

bind touch_sample_filter_calibrate_unit tsfc_checker u_tsfc_checker (.*);
